@@ rtl/core/mtri_pkg.sv @@
// Shared constants for the moving-triangle ray intersection block.
package mtri_pkg;

  localparam int DEF_COORD_BITS = 21;
  localparam int DEF_DIST_BITS  = 32;

  localparam int ALPHA_W = 17;
  localparam int FACE_W  = 20;
  localparam int SECT_W  = 8;
  localparam int MARK_W  = 2;
  localparam int CFG_W   = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
  localparam logic [CFG_W-1:0]   CFG_RESET = 32'hFFFF_FFFF;

  // 0.001 in Q16.16, rounded up
  localparam int MIN_DIST = 66;

  // power of two, so the queue pointers wrap on their own
  localparam int QUEUE_DEPTH = 2;

  localparam int MARK_FIRST = 0;
  localparam int MARK_LAST  = 1;

endpackage

@@ rtl/core/mtri_front.sv @@
// Front end: takes requests, clamps the blend fraction and packs one queue item.
module mtri_front import mtri_pkg::*; #(
  parameter int CB = DEF_COORD_BITS,
  parameter int W  = 24 * CB + ALPHA_W + FACE_W + SECT_W + MARK_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [3*CB-1:0]   ray_origin_i,
  input  logic [3*CB-1:0]   ray_dir_i,
  input  logic [3*CB-1:0]   before_vertex_a_i,
  input  logic [3*CB-1:0]   before_vertex_b_i,
  input  logic [3*CB-1:0]   before_vertex_c_i,
  input  logic [3*CB-1:0]   after_vertex_a_i,
  input  logic [3*CB-1:0]   after_vertex_b_i,
  input  logic [3*CB-1:0]   after_vertex_c_i,
  input  logic [ALPHA_W-1:0] blend_fraction_i,
  input  logic [FACE_W-1:0] face_id_i,
  input  logic [SECT_W-1:0] section_id_i,
  input  logic [MARK_W-1:0] ray_mark_i,
  output logic              item_valid_o,
  output logic [W-1:0]      item_o,
  input  logic              item_ready_i
);

  logic               vld_q;
  logic [W-1:0]       item_q;
  logic [ALPHA_W-1:0] alpha_c;

  // blend fractions above one mean fully moved
  assign alpha_c = (blend_fraction_i > ALPHA_ONE) ? ALPHA_ONE : blend_fraction_i;

  assign in_ready_o   = !vld_q || item_ready_i;
  assign item_valid_o = vld_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= {ray_mark_i[MARK_LAST], ray_mark_i[MARK_FIRST], section_id_i, face_id_i,
                 alpha_c, after_vertex_c_i, after_vertex_b_i, after_vertex_a_i,
                 before_vertex_c_i, before_vertex_b_i, before_vertex_a_i,
                 ray_dir_i, ray_origin_i};
    end
  end

endmodule

@@ rtl/core/mtri_queue.sv @@
// Short queue between the front end and the intersection back end.
module mtri_queue import mtri_pkg::*; #(
  parameter int W = 24 * DEF_COORD_BITS + ALPHA_W + FACE_W + SECT_W + MARK_W
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_valid_i,
  output logic         wr_ready_o,
  input  logic [W-1:0] wr_data_i,
  output logic         rd_valid_o,
  input  logic         rd_ready_i,
  output logic [W-1:0] rd_data_o
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] cnt_q;
  logic          push, pop;

  assign wr_ready_o = cnt_q != NW'(QUEUE_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

@@ rtl/core/mtri_back.sv @@
// Back end: blend, Moller-Trumbore test on a shared multiplier, serial divider, nearest hit.
module mtri_back import mtri_pkg::*; #(
  parameter int CB = DEF_COORD_BITS,
  parameter int DB = DEF_DIST_BITS,
  parameter int W  = 24 * CB + ALPHA_W + FACE_W + SECT_W + MARK_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  logic [W-1:0]       item_i,
  output logic               item_ready_o,
  input  logic [CFG_W-1:0]   max_range_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [CFG_W-1:0]   hit_distance_o,
  output logic [ALPHA_W-1:0] bary_u_o,
  output logic [ALPHA_W-1:0] bary_w_o,
  output logic [FACE_W-1:0]  hit_face_o,
  output logic [SECT_W-1:0]  hit_section_o
);

  localparam int V3   = 3 * CB;
  localparam int V    = CB + 1;
  localparam int E    = CB + 2;
  localparam int P    = 2 * CB + 3;
  localparam int Q    = 2 * CB + 5;
  localparam int L    = CB + 3;
  localparam int MA   = L + 1;
  localparam int MB   = (E > ALPHA_W + 1) ? E : ALPHA_W + 1;
  localparam int PR   = MA + MB;
  localparam int ACC  = 3 * CB + 9;
  localparam int NW   = (DB > CFG_W) ? DB : CFG_W;
  localparam int SW   = (DB > ALPHA_W) ? DB : ALPHA_W;
  localparam int DCW  = $clog2(SW + 1);
  localparam int TSH  = 26;
  localparam int NFW  = ACC + TSH;
  localparam int RW   = NFW - DB;
  localparam int CW   = (RW > ACC) ? RW : ACC;
  localparam int OFS_ALPHA = 8 * V3;
  localparam int OFS_FACE  = OFS_ALPHA + ALPHA_W;
  localparam int OFS_SECT  = OFS_FACE + FACE_W;
  localparam int OFS_FIRST = OFS_SECT + SECT_W;
  localparam int OFS_LAST  = OFS_FIRST + 1;

  typedef enum logic [3:0] {
    PH_IDLE, PH_BLEND, PH_CRS_P, PH_CRS_Q, PH_DOT_DET, PH_DOT_NU, PH_DOT_NW, PH_DOT_NT,
    PH_NORM, PH_CHECK, PH_DIV_T, PH_TCHK, PH_DIV_U, PH_DIV_W, PH_FINISH
  } phase_e;

  typedef enum logic [2:0] {
    DST_NONE, DST_VTX, DST_P, DST_Q, DST_DET, DST_NU, DST_NW, DST_NT
  } dst_e;

  typedef struct packed {
    logic       vld;
    logic       clr;
    logic       neg;
    logic       shl;
    logic       wr;
    dst_e       dst;
    logic [1:0] k;
    logic [1:0] h;
  } ctl_t;

  phase_e phase_q, next_ph;
  logic [1:0] k_q, h_q, k1, k2;
  logic drain_q, issue, last_h, last_k;
  ctl_t ctl_d, ctl_q;

  logic [W-1:0] item_q;
  logic signed [CB-1:0] org_c [3];
  logic signed [CB-1:0] dir_c [3];
  logic signed [CB-1:0] bv_c [3][3];
  logic signed [CB-1:0] av_c [3][3];
  logic signed [V-1:0]  vtx_q [3][3];
  logic signed [E-1:0]  e1_c [3];
  logic signed [E-1:0]  e2_c [3];
  logic signed [E-1:0]  x_c [3];
  logic signed [P-1:0]  p_q [3];
  logic signed [Q-1:0]  q_q [3];
  logic signed [ACC-1:0] det_q, nu_q, nw_q, nt_q, acc_q, acc_n, pe, psh;
  logic signed [MA-1:0] ma;
  logic signed [MB-1:0] mb;
  logic signed [PR-1:0] prod_d, prod_q, rnd_full;
  logic signed [V-1:0]  blend_v;

  logic [ACC-1:0] rem_q, rem_n, r2;
  logic [SW-1:0]  sh_q, quot_q, quot_n;
  logic [DCW-1:0] dcnt_q;
  logic           ge;
  logic [NFW-1:0] nfull;
  logic [CW-1:0]  rinit;
  logic           sat, bounds_ok, t_ok;
  logic signed [ACC:0] nuw;
  logic [DB-1:0]      t_q;
  logic [ALPHA_W-1:0] u_q;

  logic [NW-1:0]      near_q;
  logic               any_q;
  logic [ALPHA_W-1:0] bu_q, bw_q;
  logic [FACE_W-1:0]  bface_q;
  logic [SECT_W-1:0]  bsect_q;

  logic               out_valid_q, found_q;
  logic [CFG_W-1:0]   dist_q;
  logic [ALPHA_W-1:0] ou_q, ow_q;
  logic [FACE_W-1:0]  oface_q;
  logic [SECT_W-1:0]  osect_q;

  assign item_ready_o   = phase_q == PH_IDLE;
  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign hit_distance_o = dist_q;
  assign bary_u_o       = ou_q;
  assign bary_w_o       = ow_q;
  assign hit_face_o     = oface_q;
  assign hit_section_o  = osect_q;

  // unpack the held item and form edges and origin offset
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      org_c[i] = $signed(item_q[i*CB +: CB]);
      dir_c[i] = $signed(item_q[V3 + i*CB +: CB]);
      for (int j = 0; j < 3; j++) begin
        bv_c[j][i] = $signed(item_q[(2+j)*V3 + i*CB +: CB]);
        av_c[j][i] = $signed(item_q[(5+j)*V3 + i*CB +: CB]);
      end
      e1_c[i] = E'(vtx_q[1][i]) - E'(vtx_q[0][i]);
      e2_c[i] = E'(vtx_q[2][i]) - E'(vtx_q[0][i]);
      x_c[i]  = E'(org_c[i]) - E'(vtx_q[0][i]);
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    k1     = (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
    k2     = (k_q == 2'd0) ? 2'd2 : k_q - 2'd1;
    last_h = (phase_q == PH_BLEND) ? (h_q == 2'd2) : (h_q == 2'd1);
    last_k = k_q == 2'd2;
    ma     = '0;
    mb     = '0;
    ctl_d  = '0;
    issue  = 1'b0;
    next_ph = PH_NORM;
    case (phase_q)
      PH_BLEND: begin
        ma = MA'(av_c[h_q][k_q]) - MA'(bv_c[h_q][k_q]);
        mb = MB'($signed({1'b0, item_q[OFS_ALPHA +: ALPHA_W]}));
        ctl_d.dst = DST_VTX;
        ctl_d.clr = 1'b1;
        ctl_d.wr  = 1'b1;
        next_ph = PH_CRS_P;
      end
      PH_CRS_P, PH_CRS_Q: begin
        if (phase_q == PH_CRS_P) begin
          ma = (h_q == 2'd0) ? MA'(dir_c[k1]) : MA'(dir_c[k2]);
          mb = (h_q == 2'd0) ? MB'(e2_c[k2]) : MB'(e2_c[k1]);
          ctl_d.dst = DST_P;
          next_ph = PH_CRS_Q;
        end else begin
          ma = (h_q == 2'd0) ? MA'(x_c[k1]) : MA'(x_c[k2]);
          mb = (h_q == 2'd0) ? MB'(e1_c[k2]) : MB'(e1_c[k1]);
          ctl_d.dst = DST_Q;
          next_ph = PH_DOT_DET;
        end
        ctl_d.clr = h_q == 2'd0;
        ctl_d.neg = h_q == 2'd1;
        ctl_d.wr  = h_q == 2'd1;
      end
      PH_DOT_DET, PH_DOT_NU: begin
        ma = (h_q == 2'd0) ? MA'($signed(p_q[k_q][P-1:L])) : MA'({1'b0, p_q[k_q][L-1:0]});
        mb = (phase_q == PH_DOT_DET) ? MB'(e1_c[k_q]) : MB'(x_c[k_q]);
        ctl_d.dst = (phase_q == PH_DOT_DET) ? DST_DET : DST_NU;
        next_ph   = (phase_q == PH_DOT_DET) ? PH_DOT_NU : PH_DOT_NW;
        ctl_d.shl = h_q == 2'd0;
        ctl_d.clr = (k_q == 2'd0) && (h_q == 2'd0);
        ctl_d.wr  = last_k && last_h;
      end
      PH_DOT_NW, PH_DOT_NT: begin
        ma = (h_q == 2'd0) ? MA'($signed(q_q[k_q][Q-1:L])) : MA'({1'b0, q_q[k_q][L-1:0]});
        mb = (phase_q == PH_DOT_NW) ? MB'(dir_c[k_q]) : MB'(e2_c[k_q]);
        ctl_d.dst = (phase_q == PH_DOT_NW) ? DST_NW : DST_NT;
        next_ph   = (phase_q == PH_DOT_NW) ? PH_DOT_NT : PH_NORM;
        ctl_d.shl = h_q == 2'd0;
        ctl_d.clr = (k_q == 2'd0) && (h_q == 2'd0);
        ctl_d.wr  = last_k && last_h;
      end
      default: ;
    endcase
    if (phase_q == PH_BLEND || phase_q == PH_CRS_P || phase_q == PH_CRS_Q ||
        phase_q == PH_DOT_DET || phase_q == PH_DOT_NU || phase_q == PH_DOT_NW ||
        phase_q == PH_DOT_NT) begin
      issue = !drain_q;
    end
    ctl_d.vld = issue;
    ctl_d.wr  = ctl_d.wr && issue;
    ctl_d.k   = k_q;
    ctl_d.h   = h_q;
  end

  assign prod_d = ma * mb;

  // accumulate the registered product
  always_comb begin
    pe       = ACC'(prod_q);
    psh      = ctl_q.shl ? (pe <<< L) : pe;
    acc_n    = (ctl_q.clr ? '0 : acc_q) + (ctl_q.neg ? -psh : psh);
    rnd_full = (prod_q + PR'(32768)) >>> 16;
    blend_v  = V'(bv_c[ctl_q.h][ctl_q.k]) + V'(rnd_full);
  end

  // restoring divider step and operand checks
  always_comb begin
    r2     = {rem_q[ACC-2:0], sh_q[SW-1]};
    ge     = r2 >= $unsigned(det_q);
    rem_n  = ge ? r2 - $unsigned(det_q) : r2;
    quot_n = {quot_q[SW-2:0], ge};
    nfull  = {nt_q, {TSH{1'b0}}};
    rinit  = CW'(nfull >> DB);
    sat    = rinit >= CW'($unsigned(det_q));
    nuw    = (ACC+1)'(nu_q) + (ACC+1)'(nw_q);
    bounds_ok = !nu_q[ACC-1] && (nu_q <= det_q) && !nw_q[ACC-1] &&
                (nuw <= (ACC+1)'(det_q)) && !nt_q[ACC-1];
    t_ok   = (t_q >= DB'(MIN_DIST)) && (NW'(t_q) < near_q);
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctl_q.vld) begin
      acc_q <= acc_n;
      if (ctl_q.wr) begin
        case (ctl_q.dst)
          DST_VTX: vtx_q[ctl_q.h][ctl_q.k] <= blend_v;
          DST_P:   p_q[ctl_q.k] <= acc_n[P-1:0];
          DST_Q:   q_q[ctl_q.k] <= acc_n[Q-1:0];
          DST_DET: det_q <= acc_n;
          DST_NU:  nu_q <= acc_n;
          DST_NW:  nw_q <= acc_n;
          DST_NT:  nt_q <= acc_n;
          default: ;
        endcase
      end
    end
    case (phase_q)
      PH_IDLE: begin
        if (item_valid_i) item_q <= item_i;
      end
      PH_NORM: begin
        // make the determinant positive, flip the numerators with it
        if (!drain_q && det_q[ACC-1]) begin
          det_q <= -det_q;
          nu_q  <= -nu_q;
          nw_q  <= -nw_q;
          nt_q  <= -nt_q;
        end
      end
      PH_CHECK: begin
        rem_q  <= rinit[ACC-1:0];
        sh_q   <= SW'(nfull[DB-1:0]) << (SW - DB);
        dcnt_q <= DCW'(DB);
        t_q    <= '1;
      end
      PH_DIV_T, PH_DIV_U, PH_DIV_W: begin
        rem_q  <= rem_n;
        sh_q   <= sh_q << 1;
        quot_q <= quot_n;
        dcnt_q <= dcnt_q - 1'b1;
        if (dcnt_q == DCW'(1)) begin
          if (phase_q == PH_DIV_T) t_q <= quot_n[DB-1:0];
          if (phase_q == PH_DIV_U) begin
            u_q    <= quot_n[ALPHA_W-1:0];
            rem_q  <= ACC'(nw_q[ACC-1:1]);
            sh_q   <= {nw_q[0], {(SW-1){1'b0}}};
            dcnt_q <= DCW'(ALPHA_W);
          end
        end
      end
      PH_TCHK: begin
        rem_q  <= ACC'(nu_q[ACC-1:1]);
        sh_q   <= {nu_q[0], {(SW-1){1'b0}}};
        dcnt_q <= DCW'(ALPHA_W);
      end
      default: ;
    endcase
  end

  // sequencer, ray state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      k_q         <= '0;
      h_q         <= '0;
      drain_q     <= 1'b0;
      ctl_q       <= '0;
      near_q      <= NW'(CFG_RESET);
      any_q       <= 1'b0;
      bu_q        <= '0;
      bw_q        <= '0;
      bface_q     <= '0;
      bsect_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      dist_q      <= '0;
      ou_q        <= '0;
      ow_q        <= '0;
      oface_q     <= '0;
      osect_q     <= '0;
    end else begin
      ctl_q <= ctl_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (drain_q) begin
        drain_q <= 1'b0;
      end else begin
        case (phase_q)
          PH_IDLE: begin
            if (item_valid_i) begin
              phase_q <= PH_BLEND;
              k_q     <= '0;
              h_q     <= '0;
              if (item_i[OFS_FIRST]) begin
                near_q  <= NW'(max_range_i);
                any_q   <= 1'b0;
                bu_q    <= '0;
                bw_q    <= '0;
                bface_q <= '0;
                bsect_q <= '0;
              end
            end
          end
          PH_BLEND, PH_CRS_P, PH_CRS_Q, PH_DOT_DET, PH_DOT_NU, PH_DOT_NW, PH_DOT_NT: begin
            if (last_h) begin
              h_q <= '0;
              if (last_k) begin
                k_q     <= '0;
                phase_q <= next_ph;
                drain_q <= 1'b1;
              end else begin
                k_q <= k_q + 2'd1;
              end
            end else begin
              h_q <= h_q + 2'd1;
            end
          end
          PH_NORM: begin
            phase_q <= (det_q == '0) ? PH_FINISH : PH_CHECK;
          end
          PH_CHECK: begin
            if (!bounds_ok) begin
              phase_q <= PH_FINISH;
            end else if (sat) begin
              phase_q <= PH_TCHK;
            end else begin
              phase_q <= PH_DIV_T;
            end
          end
          PH_DIV_T: begin
            if (dcnt_q == DCW'(1)) phase_q <= PH_TCHK;
          end
          PH_TCHK: begin
            phase_q <= t_ok ? PH_DIV_U : PH_FINISH;
          end
          PH_DIV_U: begin
            if (dcnt_q == DCW'(1)) phase_q <= PH_DIV_W;
          end
          PH_DIV_W: begin
            if (dcnt_q == DCW'(1)) begin
              near_q  <= NW'(t_q);
              any_q   <= 1'b1;
              bu_q    <= u_q;
              bw_q    <= quot_n[ALPHA_W-1:0];
              bface_q <= item_q[OFS_FACE +: FACE_W];
              bsect_q <= item_q[OFS_SECT +: SECT_W];
              phase_q <= PH_FINISH;
            end
          end
          PH_FINISH: begin
            if (!item_q[OFS_LAST]) begin
              phase_q <= PH_IDLE;
            end else if (!out_valid_q || out_ready_i) begin
              out_valid_q <= 1'b1;
              found_q     <= any_q;
              dist_q      <= any_q ? near_q[CFG_W-1:0] : '0;
              ou_q        <= bu_q;
              ow_q        <= bw_q;
              oface_q     <= bface_q;
              osect_q     <= bsect_q;
              near_q      <= NW'(max_range_i);
              any_q       <= 1'b0;
              bu_q        <= '0;
              bw_q        <= '0;
              bface_q     <= '0;
              bsect_q     <= '0;
              phase_q     <= PH_IDLE;
            end
          end
          default: phase_q <= PH_IDLE;
        endcase
      end
    end
  end

endmodule

@@ rtl/core/moving_triangle_ray_intersect.sv @@
// Top level of the moving-triangle ray intersection block.
//
// Each request on the input channel (in_valid_i/in_ready_o) is one triangle,
// given before and after motion, tested against one ray in local space. The
// vertices are blended by blend_fraction_i and tested by Moller-Trumbore in
// exact fixed point; the nearest accepted hit of the ray is kept. ray_mark_i
// bit 0 starts a ray, bit 1 ends it; a ray end puts one result on the output
// channel (out_valid_o/out_ready_i): found flag, Q16.16 distance, barycentrics
// and the ids of the nearest hit.
// Requests pass an input register and a two-entry queue into the back end, so
// up to three requests are taken while the back end is busy. The back end runs
// one triangle at a time: arithmetic on its one shared 25x23 multiplier, then a
// one-bit-per-cycle divider (DIST_BITS quotient bits for the distance, 17 each
// for the two barycentrics). A result waits in the output register while the
// receiver stalls; the back end holds only at the end of a ray whose result
// cannot yet be placed. Reset empties the queue and sets max_range to all
// ones. cfg_data_i writes max_range; it takes effect when the next ray starts.
module moving_triangle_ray_intersect import mtri_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int DIST_BITS  = DEF_DIST_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [3*COORD_BITS-1:0] ray_origin_i,
  input  logic [3*COORD_BITS-1:0] ray_dir_i,
  input  logic [3*COORD_BITS-1:0] before_vertex_a_i,
  input  logic [3*COORD_BITS-1:0] before_vertex_b_i,
  input  logic [3*COORD_BITS-1:0] before_vertex_c_i,
  input  logic [3*COORD_BITS-1:0] after_vertex_a_i,
  input  logic [3*COORD_BITS-1:0] after_vertex_b_i,
  input  logic [3*COORD_BITS-1:0] after_vertex_c_i,
  input  logic [ALPHA_W-1:0]      blend_fraction_i,
  input  logic [FACE_W-1:0]       face_id_i,
  input  logic [SECT_W-1:0]       section_id_i,
  input  logic [MARK_W-1:0]       ray_mark_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_W-1:0]        cfg_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    found_o,
  output logic [CFG_W-1:0]        hit_distance_o,
  output logic [ALPHA_W-1:0]      bary_u_o,
  output logic [ALPHA_W-1:0]      bary_w_o,
  output logic [FACE_W-1:0]       hit_face_o,
  output logic [SECT_W-1:0]       hit_section_o
);

  // one queue item: ray, six vertices, clamped fraction, ids, first/last marks
  localparam int ITEM_W = 24 * COORD_BITS + ALPHA_W + FACE_W + SECT_W + MARK_W;

  logic              fr_valid, fr_ready, bk_valid, bk_ready;
  logic [ITEM_W-1:0] fr_item, bk_item;
  logic [CFG_W-1:0]  max_range_q;

  // the register is always writable; it is read when a ray starts or ends
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_range_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      max_range_q <= cfg_data_i;
    end
  end

  mtri_front #(.CB(COORD_BITS), .W(ITEM_W)) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .ray_origin_i      (ray_origin_i),
    .ray_dir_i         (ray_dir_i),
    .before_vertex_a_i (before_vertex_a_i),
    .before_vertex_b_i (before_vertex_b_i),
    .before_vertex_c_i (before_vertex_c_i),
    .after_vertex_a_i  (after_vertex_a_i),
    .after_vertex_b_i  (after_vertex_b_i),
    .after_vertex_c_i  (after_vertex_c_i),
    .blend_fraction_i  (blend_fraction_i),
    .face_id_i         (face_id_i),
    .section_id_i      (section_id_i),
    .ray_mark_i        (ray_mark_i),
    .item_valid_o      (fr_valid),
    .item_o            (fr_item),
    .item_ready_i      (fr_ready)
  );

  // decouple request intake from the long per-triangle computation
  mtri_queue #(.W(ITEM_W)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_item),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_data_o  (bk_item)
  );

  mtri_back #(.CB(COORD_BITS), .DB(DIST_BITS), .W(ITEM_W)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (bk_valid),
    .item_i         (bk_item),
    .item_ready_o   (bk_ready),
    .max_range_i    (max_range_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .hit_distance_o (hit_distance_o),
    .bary_u_o       (bary_u_o),
    .bary_w_o       (bary_w_o),
    .hit_face_o     (hit_face_o),
    .hit_section_o  (hit_section_o)
  );

endmodule

@@ tb/tb_moving_triangle_ray_intersect.sv @@
// Self-checking testbench for the moving-triangle ray intersection block.
module tb_moving_triangle_ray_intersect;
  import mtri_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB        = DEF_COORD_BITS;
  localparam int DB        = DEF_DIST_BITS;
  localparam int VW        = 3 * CB;
  localparam int WDOG_MAX  = 20000;
  localparam int HOLD_LEN  = 600;
  localparam int TAIL_WAIT = 1000;

  typedef longint vec3_t [0:2];
  typedef logic signed [127:0] s128_t;

  typedef struct packed {
    logic [VW-1:0]      origin;
    logic [VW-1:0]      dir;
    logic [VW-1:0]      ba, bb, bc;
    logic [VW-1:0]      aa, ab, ac;
    logic [ALPHA_W-1:0] alpha;
    logic [FACE_W-1:0]  face;
    logic [SECT_W-1:0]  sect;
    logic [MARK_W-1:0]  mark;
  } tri_req_t;

  typedef struct packed {
    logic               found;
    logic [CFG_W-1:0]   hdist;
    logic [ALPHA_W-1:0] u;
    logic [ALPHA_W-1:0] w;
    logic [FACE_W-1:0]  face;
    logic [SECT_W-1:0]  sect;
  } hit_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic found_o;
  logic [CFG_W-1:0] hit_distance_o;
  logic [ALPHA_W-1:0] bary_u_o, bary_w_o;
  logic [FACE_W-1:0] hit_face_o;
  logic [SECT_W-1:0] hit_section_o;

  tri_req_t cur_req = '0;

  moving_triangle_ray_intersect u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .ray_origin_i     (cur_req.origin),
    .ray_dir_i        (cur_req.dir),
    .before_vertex_a_i(cur_req.ba),
    .before_vertex_b_i(cur_req.bb),
    .before_vertex_c_i(cur_req.bc),
    .after_vertex_a_i (cur_req.aa),
    .after_vertex_b_i (cur_req.ab),
    .after_vertex_c_i (cur_req.ac),
    .blend_fraction_i (cur_req.alpha),
    .face_id_i        (cur_req.face),
    .section_id_i     (cur_req.sect),
    .ray_mark_i       (cur_req.mark),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .found_o          (found_o),
    .hit_distance_o   (hit_distance_o),
    .bary_u_o         (bary_u_o),
    .bary_w_o         (bary_w_o),
    .hit_face_o       (hit_face_o),
    .hit_section_o    (hit_section_o)
  );

  // Pending triangle requests, expected ray results, and the tracked ray state.
  tri_req_t   pend_q[$];
  hit_rec_t   hit_q[$];
  logic [CFG_W-1:0] range_reg = CFG_RESET;
  logic [CFG_W-1:0] near_dist = CFG_RESET;
  hit_rec_t   best = '0;
  int         send_idle = 0, recv_idle = 0;
  int         err_cnt = 0;
  int         rays_seen = 0;
  int         hold_left = 0;
  bit         held_once = 1'b0;
  int         quiet_cnt = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction: exact fixed-point blend plus Moller-Trumbore
  // ---------------------------------------------------------------------------
  function automatic vec3_t split3(logic [VW-1:0] p);
    vec3_t v;
    for (int i = 0; i < 3; i++) v[i] = longint'($signed(p[i*CB +: CB]));
    return v;
  endfunction

  function automatic vec3_t lerp3(logic [VW-1:0] b, logic [VW-1:0] a, longint al);
    vec3_t vb, va, r;
    longint x;
    vb = split3(b);
    va = split3(a);
    for (int i = 0; i < 3; i++) begin
      x = (va[i] - vb[i]) * al + 32768;
      r[i] = vb[i] + (x >>> 16);
    end
    return r;
  endfunction

  function automatic vec3_t cross3(vec3_t a, vec3_t b);
    vec3_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  function automatic s128_t dot3(vec3_t a, vec3_t b);
    return s128_t'(a[0]) * s128_t'(b[0]) + s128_t'(a[1]) * s128_t'(b[1])
         + s128_t'(a[2]) * s128_t'(b[2]);
  endfunction

  // Advance the ray state by one triangle; push a result on a ray end.
  task automatic test_triangle(tri_req_t r);
    vec3_t o, d, va, vb, vc, e1, e2, x, p, q;
    s128_t det, nu, nw, nt;
    logic [127:0] tq;
    logic [CFG_W-1:0] t;
    longint al;
    hit_rec_t res;
    al = (r.alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(r.alpha);
    if (r.mark[MARK_FIRST]) begin
      near_dist = range_reg;
      best = '0;
    end
    o  = split3(r.origin);
    d  = split3(r.dir);
    va = lerp3(r.ba, r.aa, al);
    vb = lerp3(r.bb, r.ab, al);
    vc = lerp3(r.bc, r.ac, al);
    for (int i = 0; i < 3; i++) begin
      e1[i] = vb[i] - va[i];
      e2[i] = vc[i] - va[i];
      x[i]  = o[i] - va[i];
    end
    p   = cross3(d, e2);
    det = dot3(e1, p);
    if (det != 0) begin
      nu = dot3(x, p);
      q  = cross3(x, e1);
      nw = dot3(d, q);
      nt = dot3(e2, q);
      if (det < 0) begin
        det = -det; nu = -nu; nw = -nw; nt = -nt;
      end
      if (nu >= 0 && nu <= det && nw >= 0 && nu + nw <= det && nt >= 0) begin
        tq = (128'(nt) << 26) / 128'(det);
        t  = (tq > 128'({DB{1'b1}})) ? {DB{1'b1}} : tq[CFG_W-1:0];
        if (t >= MIN_DIST && t < near_dist) begin
          near_dist  = t;
          best.found = 1'b1;
          best.u     = 17'(((128'(nu) << 16) / 128'(det)));
          best.w     = 17'(((128'(nw) << 16) / 128'(det)));
          best.face  = r.face;
          best.sect  = r.sect;
        end
      end
    end
    if (r.mark[MARK_LAST]) begin
      res = best;
      res.hdist = best.found ? near_dist : '0;
      hit_q.push_back(res);
      near_dist = range_reg;
      best = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: hold a request until accepted, idle at random between requests
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) test_triangle(cur_req);
    if (!in_valid_i || in_ready_o) begin
      if (pend_q.size() != 0 && rst_ni && $urandom_range(99) >= send_idle) begin
        cur_req    <= pend_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver and result check
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    hit_rec_t e;
    if (out_valid_o && out_ready_i) begin
      rays_seen <= rays_seen + 1;
      if (hit_q.size() == 0) begin
        $error("result with no request pending");
        err_cnt++;
      end else begin
        e = hit_q.pop_front();
        if (found_o !== e.found) begin
          $error("found exp %0d got %0d", e.found, found_o); err_cnt++;
        end
        if (hit_distance_o !== e.hdist) begin
          $error("hit_distance exp %0h got %0h", e.hdist, hit_distance_o); err_cnt++;
        end
        if (bary_u_o !== e.u) begin
          $error("bary_u exp %0h got %0h", e.u, bary_u_o); err_cnt++;
        end
        if (bary_w_o !== e.w) begin
          $error("bary_w exp %0h got %0h", e.w, bary_w_o); err_cnt++;
        end
        if (hit_face_o !== e.face) begin
          $error("hit_face exp %0h got %0h", e.face, hit_face_o); err_cnt++;
        end
        if (hit_section_o !== e.sect) begin
          $error("hit_section exp %0h got %0h", e.sect, hit_section_o); err_cnt++;
        end
      end
    end
    // One long stall after the twentieth ray result, so the input backs up.
    if (!held_once && rays_seen == 20) begin
      held_once <= 1'b1;
      hold_left <= HOLD_LEN;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= WDOG_MAX) begin
      $display("tb_moving_triangle_ray_intersect: errors");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic longint srnd(int m);
    return longint'($urandom_range(2 * m)) - m;
  endfunction

  function automatic logic [VW-1:0] pack3(longint x, longint y, longint z);
    logic [CB-1:0] px, py, pz;
    px = x[CB-1:0];
    py = y[CB-1:0];
    pz = z[CB-1:0];
    return {pz, py, px};
  endfunction

  function automatic logic [VW-1:0] rnd_vec();
    return VW'({$urandom, $urandom});
  endfunction

  function automatic tri_req_t noise_req();
    tri_req_t r;
    r.origin = rnd_vec(); r.dir = rnd_vec();
    r.ba = rnd_vec(); r.bb = rnd_vec(); r.bc = rnd_vec();
    r.aa = rnd_vec(); r.ab = rnd_vec(); r.ac = rnd_vec();
    r.alpha = ALPHA_W'($urandom);
    r.face  = FACE_W'($urandom);
    r.sect  = SECT_W'($urandom);
    r.mark  = MARK_W'($urandom);
    return r;
  endfunction

  // Build a triangle around the point at ray parameter tpar (negative: behind).
  function automatic tri_req_t aimed_req(vec3_t o, vec3_t d, longint tpar, int rad,
                                         int drift, logic [MARK_W-1:0] mark);
    tri_req_t r;
    vec3_t c;
    longint b[0:2][0:2];
    for (int i = 0; i < 3; i++) c[i] = o[i] + ((d[i] * tpar) >>> 10);
    for (int v = 0; v < 3; v++)
      for (int i = 0; i < 3; i++) b[v][i] = c[i] + srnd(rad);
    r.origin = pack3(o[0], o[1], o[2]);
    r.dir    = pack3(d[0], d[1], d[2]);
    r.ba = pack3(b[0][0], b[0][1], b[0][2]);
    r.bb = pack3(b[1][0], b[1][1], b[1][2]);
    r.bc = pack3(b[2][0], b[2][1], b[2][2]);
    r.aa = pack3(b[0][0] + srnd(drift), b[0][1] + srnd(drift), b[0][2] + srnd(drift));
    r.ab = pack3(b[1][0] + srnd(drift), b[1][1] + srnd(drift), b[1][2] + srnd(drift));
    r.ac = pack3(b[2][0] + srnd(drift), b[2][1] + srnd(drift), b[2][2] + srnd(drift));
    r.alpha = ($urandom_range(9) == 0) ? ALPHA_W'($urandom_range(131071, 65536))
                                       : ALPHA_W'($urandom_range(65536));
    r.face  = FACE_W'($urandom);
    r.sect  = SECT_W'($urandom);
    r.mark  = mark;
    return r;
  endfunction

  function automatic vec3_t rnd_origin();
    vec3_t o;
    for (int i = 0; i < 3; i++) o[i] = srnd(1 << 16);
    return o;
  endfunction

  function automatic vec3_t rnd_dir();
    vec3_t d;
    for (int i = 0; i < 3; i++) d[i] = srnd(1 << 18);
    if (d[0] == 0 && d[1] == 0 && d[2] == 0) d[2] = 1 << 18;
    return d;
  endfunction

  // Queue one ray of n triangles; return the number of requests queued.
  function automatic int push_ray(int n);
    vec3_t o, d;
    logic [MARK_W-1:0] m;
    int rad;
    o = rnd_origin();
    d = rnd_dir();
    rad = ($urandom_range(3) == 0) ? 8000 : 1500;
    for (int k = 0; k < n; k++) begin
      m = '0;
      m[MARK_FIRST] = (k == 0) && ($urandom_range(7) != 0);
      m[MARK_LAST]  = (k == n - 1);
      if ($urandom_range(11) == 0)
        pend_q.push_back(noise_req());
      else
        pend_q.push_back(aimed_req(o, d, $urandom_range(64, 1), rad, 400, m));
    end
    return n;
  endfunction

  task automatic drain();
    while (pend_q.size() != 0 || in_valid_i || hit_q.size() != 0) @(posedge clk_i);
    // Triangles without a ray end may still be in the front, queue and back end.
    repeat (TAIL_WAIT) @(posedge clk_i);
  endtask

  task automatic write_range(logic [CFG_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    range_reg = v;
  endtask

  task automatic push_directed();
    vec3_t o, d;
    tri_req_t r;
    o = rnd_origin();
    d = rnd_dir();
    // Degenerate triangle: zero determinant.
    r = aimed_req(o, d, 10, 0, 0, 2'b11);
    r.bb = r.ba; r.bc = r.ba; r.ab = r.aa; r.ac = r.aa;
    pend_q.push_back(r);
    // Too near (on the origin) and behind the origin.
    pend_q.push_back(aimed_req(o, d, 0, 3, 0, 2'b11));
    pend_q.push_back(aimed_req(o, d, -20, 1500, 0, 2'b11));
    // Same triangle twice: the second is not nearer.
    r = aimed_req(o, d, 20, 1500, 0, 2'b01);
    pend_q.push_back(r);
    r.mark = 2'b10;
    r.face = ~r.face;
    pend_q.push_back(r);
    // Nearer triangle later in the ray, with blend at one, above one and zero.
    r = aimed_req(o, d, 40, 1500, 300, 2'b01);
    r.alpha = ALPHA_ONE;
    pend_q.push_back(r);
    r = aimed_req(o, d, 5, 1500, 300, 2'b00);
    r.alpha = '1;
    pend_q.push_back(r);
    r = aimed_req(o, d, 30, 1500, 300, 2'b10);
    r.alpha = '0;
    pend_q.push_back(r);
    // Ray lacking a first mark, and a triangle with neither mark.
    pend_q.push_back(aimed_req(o, d, 12, 1500, 0, 2'b00));
    pend_q.push_back(aimed_req(o, d, 25, 1500, 0, 2'b10));
    // Field extremes.
    r = '1;
    r.mark = 2'b11;
    pend_q.push_back(r);
    r = '0;
    r.mark = 2'b11;
    pend_q.push_back(r);
    r = '0;
    r.origin = pack3(-(1 << 20), -(1 << 20), -(1 << 20));
    r.dir = pack3((1 << 20) - 1, (1 << 20) - 1, (1 << 20) - 1);
    r.bb = pack3((1 << 20) - 1, 0, 0);
    r.bc = pack3(0, (1 << 20) - 1, 0);
    r.ab = r.bb; r.ac = r.bc;
    r.aa = pack3(-(1 << 20), -(1 << 20), (1 << 20) - 1);
    r.alpha = ALPHA_ONE;
    r.face = '1; r.sect = '1; r.mark = 2'b11;
    pend_q.push_back(r);
    for (int k = 0; k < 6; k++) pend_q.push_back(noise_req());
  endtask

  // Random rays, with a full pause for the results halfway through.
  task automatic run_random(int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      sent += push_ray($urandom_range(6, 1));
      if (sent >= n_items / 2 && sent < n_items / 2 + 7) begin
        while (pend_q.size() != 0 || in_valid_i || hit_q.size() != 0) @(posedge clk_i);
      end
      if (pend_q.size() > 32) wait (pend_q.size() < 8);
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 31; recv_idle = 62;
    push_directed();
    drain();
    run_random(560);

    send_idle = 62; recv_idle = 31;
    write_range('0);
    run_random(100);
    write_range(CFG_W'($urandom_range(60, 20)) << 16);
    run_random(560);

    send_idle = 0; recv_idle = 0;
    write_range(CFG_RESET);
    run_random(600);

    repeat (TAIL_WAIT) @(posedge clk_i);
    if (err_cnt == 0 && hit_q.size() == 0) begin
      $display("tb_moving_triangle_ray_intersect: clean");
    end else begin
      $display("tb_moving_triangle_ray_intersect: errors");
    end
    $finish;
  end

endmodule
